// ===== rtl/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants of the deadline timer slot table
// Slot count, field widths, codes and the cell-to-cell struct.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int SLOTS = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NO_TIMER = 3'd2;
  localparam logic [2:0] ST_EXPIRED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [15:0] TPM_RESET = 16'd1000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [31:0] param;
    logic [31:0] context_tag;
  } tags_t;

  typedef struct packed {
    logic        active;
    logic [63:0] deadline;
    tags_t       tags;
  } slot_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] now;
    logic [5:0]  slot_id;
    logic [2:0]  status;
    logic [31:0] fired_param;
    logic [31:0] fired_context;
    logic        compare_valid;
    logic [31:0] compare_value;
    logic        last;
  } result_t;

endpackage

// ===== rtl/dts_if.sv =====
// ----------------------------------------------------------------------------
// dts_in_if / dts_out_if: valid/ready channels of the timer slot table
// One interface for input items and one for result beats.
// ----------------------------------------------------------------------------
interface dts_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] now;
  logic [31:0] delay_ms;
  logic [7:0]  timer_id;
  logic [31:0] param_tag;
  logic [31:0] context_tag;
  modport source (output valid, mode, now, delay_ms, timer_id, param_tag, context_tag,
                  input ready);
  modport sink (input valid, mode, now, delay_ms, timer_id, param_tag, context_tag,
                output ready);
endinterface

interface dts_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  slot_id;
  logic [2:0]  status;
  logic [31:0] fired_param;
  logic [31:0] fired_context;
  logic        compare_valid;
  logic [31:0] compare_value;
  logic        last;
  modport source (output valid, kind, slot_id, status, fired_param, fired_context,
                  compare_valid, compare_value, last, input ready);
  modport sink (input valid, kind, slot_id, status, fired_param, fired_context,
                compare_valid, compare_value, last, output ready);
endinterface

// ===== rtl/dts_cell.sv =====
// ----------------------------------------------------------------------------
// dts_cell: one timer slot in the rotating chain
// Holds one slot and hands it to its neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module dts_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  dts_pkg::slot_t slot_in,
  output dts_pkg::slot_t slot_out
);
  import dts_pkg::*;

  logic  active;
  logic [63:0] deadline;
  tags_t tags;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (shift) begin
      active <= slot_in.active;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      deadline <= slot_in.deadline;
      tags <= slot_in.tags;
    end
  end

  assign slot_out = '{active: active, deadline: deadline, tags: tags};

endmodule

// ===== rtl/deadline_timer_slot_table.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_slot_table: table of timer slots with one compare value
// Slots live in a ring of cells that rotates one slot per cycle in a pass when
// no fire beat stalls, past a single head where all checks and updates happen.
// ----------------------------------------------------------------------------
// Each item is latched, multiplied, taken through a find pass of the ring and
// a decide step, then through a rescan pass and a report step; fire beats that
// cannot be placed stall the passes. A failed start or cancel, or a cancel of
// an expired timer, skips the rescan; the unused mode skips both passes. Only
// one item is in flight at a time. Reset clears all active bits at once and
// sets ticks_per_ms to 1000; no clearing pass is needed.
module deadline_timer_slot_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  dts_in_if.sink      in_ch,
  dts_out_if.source   out_ch
);
  import dts_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;  // first pass: find free slot / cancel / tick
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;  // rescan pass
  localparam logic [2:0] S_REPORT = 3'd5;

  logic [15:0] ticks_per_ms;
  assign pready = 1'b1;
  assign prdata = {16'd0, ticks_per_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= TPM_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      ticks_per_ms <= pwdata[15:0];
    end
  end

  // The ring: cell i takes from cell i+1, the last cell takes the head slot.
  slot_t cell_q [SLOTS];
  slot_t cell_d [SLOTS];
  slot_t head_in;
  logic  shift;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      assign cell_d[i] = head_in;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i + 1];
    end
    dts_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .slot_in(cell_d[i]),
                     .slot_out(cell_q[i]));
  end

  slot_t head;
  assign head = cell_q[0];

  logic [2:0]  state;
  logic [1:0]  mode;
  logic [63:0] now;
  logic [31:0] delay_ms;
  logic [7:0]  timer_id;
  tags_t       new_tags;
  logic [47:0] product;
  logic [64:0] dl_sum;
  logic [SLOT_W-1:0] pos;       // index of the slot now at the head
  logic        found;
  logic [SLOT_W-1:0] found_id;
  logic [2:0]  rep_status;
  logic [5:0]  rep_slot;
  logic        do_scan;
  logic [63:0] best;
  logic        cancel_hit;

  // Result output register.
  logic        ovalid;
  logic        okind;
  logic [5:0]  oslot;
  logic [2:0]  ostatus;
  tags_t       otags;
  logic        ocv;
  logic [31:0] ocval;
  logic        olast;

  logic out_free;
  assign out_free = !ovalid || out_ch.ready;

  // Per-head decisions.
  logic fire_tick, fire_scan, take_free, emit_fire, id_match;
  assign id_match = timer_id[7:SLOT_W] == '0 && timer_id[SLOT_W-1:0] == pos;
  assign take_free = state == S_SCAN && mode == MODE_START && !head.active
                     && !found;
  assign fire_tick = state == S_FIND && mode == MODE_TICK && head.active
                     && head.deadline <= now;
  assign fire_scan = state == S_SCAN && do_scan && head.active
                     && head.deadline < best && head.deadline < now;
  assign emit_fire = fire_tick || fire_scan;

  // The ring advances in pass states unless a fire beat cannot be placed.
  assign shift = (state == S_FIND || state == S_SCAN) && (!emit_fire || out_free);

  logic [CNT_W-1:0] cnt;

  always_comb begin
    head_in = head;
    if (emit_fire) begin
      head_in.active = 1'b0;
    end else if (state == S_FIND && mode == MODE_CANCEL && id_match && head.active) begin
      // A cancelled slot is always freed; an expired one also loses its tags.
      head_in.active = 1'b0;
      if (head.deadline < now) begin
        head_in.tags = '0;
      end
    end else if (take_free && do_scan) begin
      head_in.active = 1'b1;
      head_in.deadline = dl_sum[63:0];
      head_in.tags = new_tags;
    end
  end

  assign in_ch.ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (ovalid && out_ch.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode <= in_ch.mode;
            now <= in_ch.now;
            delay_ms <= in_ch.delay_ms;
            timer_id <= in_ch.timer_id;
            new_tags <= '{param: in_ch.param_tag, context_tag: in_ch.context_tag};
            state <= S_MUL;
          end
        end
        S_MUL: begin
          product <= {16'd0, delay_ms} * {32'd0, ticks_per_ms};
          pos <= '0;
          cnt <= '0;
          found <= 1'b0;
          cancel_hit <= 1'b0;
          rep_status <= ST_OK;
          rep_slot <= '0;
          best <= ALL_ONES;
          if (mode == MODE_START || mode == MODE_CANCEL || mode == MODE_TICK) begin
            state <= S_FIND;
          end else begin
            state <= S_REPORT;
          end
        end
        S_FIND: begin
          if (mode == MODE_START) begin
            dl_sum <= {1'b0, now} + {17'd0, product};
          end
          if (shift) begin
            if (mode == MODE_START && !head.active && !found) begin
              found <= 1'b1;
              found_id <= pos;
            end
            if (mode == MODE_CANCEL && id_match && head.active) begin
              cancel_hit <= 1'b1;
              if (head.deadline < now) begin
                rep_status <= ST_EXPIRED;
              end
            end
            pos <= pos + 1'b1;
            cnt <= cnt + 1'b1;
            if (cnt == CNT_W'(SLOTS - 1)) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          pos <= '0;
          cnt <= '0;
          found <= 1'b0;
          do_scan <= 1'b1;
          state <= S_SCAN;
          case (mode)
            MODE_START: begin
              if (!found) begin
                rep_status <= ST_FULL;
                do_scan <= 1'b0;
                state <= S_REPORT;
              end else if (dl_sum[64]) begin
                rep_status <= ST_OVERFLOW;
                do_scan <= 1'b0;
                state <= S_REPORT;
              end else begin
                rep_slot <= 6'(found_id);
              end
            end
            MODE_CANCEL: begin
              rep_slot <= timer_id[5:0];
              if (!cancel_hit) begin
                rep_status <= ST_NO_TIMER;
                do_scan <= 1'b0;
                state <= S_REPORT;
              end else if (rep_status == ST_EXPIRED) begin
                do_scan <= 1'b0;
                state <= S_REPORT;
              end
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (shift) begin
            if (take_free) begin
              found <= 1'b1;  // the slot armed here is also seen by the rescan
              if (dl_sum[63:0] < best && !(dl_sum[63:0] < now)) begin
                best <= dl_sum[63:0];
              end
            end else if (head.active && head.deadline < best && !(head.deadline < now)) begin
              best <= head.deadline;
            end
            pos <= pos + 1'b1;
            cnt <= cnt + 1'b1;
            if (cnt == CNT_W'(SLOTS - 1)) begin
              state <= S_REPORT;
            end
          end
        end
        S_REPORT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            okind <= KIND_REPORT;
            oslot <= rep_slot;
            ostatus <= rep_status;
            otags <= '0;
            ocv <= do_scan && best != ALL_ONES && rep_status == ST_OK
                   && (mode == MODE_START || mode == MODE_CANCEL || mode == MODE_TICK);
            ocval <= (do_scan && best != ALL_ONES && rep_status == ST_OK)
                     ? best[31:0] : 32'd0;
            olast <= 1'b1;
            do_scan <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (emit_fire && out_free) begin
        ovalid <= 1'b1;
        okind <= KIND_FIRE;
        oslot <= 6'(pos);
        ostatus <= ST_OK;
        otags <= head.tags;
        ocv <= 1'b0;
        ocval <= '0;
        olast <= 1'b0;
      end
      if (state == S_MUL) begin
        do_scan <= mode == MODE_TICK;
      end
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.kind = okind;
  assign out_ch.slot_id = oslot;
  assign out_ch.status = ostatus;
  assign out_ch.fired_param = otags.param;
  assign out_ch.fired_context = otags.context_tag;
  assign out_ch.compare_valid = ocv;
  assign out_ch.compare_value = ocval;
  assign out_ch.last = olast;

  // A fire beat is only issued while the ring walks a pass.
  a_fire_in_pass: assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> (state == S_FIND || state == S_SCAN))
    else $error("fire outside pass");
  // Input is never taken while an item is in flight.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready)
    else $error("ready while busy");
  // The report beat always closes an item.
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    (ovalid && okind == KIND_REPORT) |-> olast)
    else $error("report without last");
  // Position and pass count move together.
  a_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pos == cnt[SLOT_W-1:0]))
    else $error("ring position lost");

endmodule
